// ----- hdl/scf_pkg.sv -----
// Package with shared constants for the signed comb filter core.
`default_nettype none

package scf_pkg;

  // Default geometry of the delay line and the sample format.
  localparam int DefaultDelayDepth = 256;
  localparam int DefaultSampleBits = 16;

  // Gain format: signed Q2.14.
  localparam int GainBits = 16;
  localparam int GainFrac = 14;

  // Configuration port layout.
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = 16;
  localparam int DelayLenBits = 8;
  localparam int ModeBits     = 2;

  // Register indexes.
  localparam logic [CfgIndexBits-1:0] REG_DELAY_LENGTH  = 2'd0;
  localparam logic [CfgIndexBits-1:0] REG_GAIN_DIRECT   = 2'd1;
  localparam logic [CfgIndexBits-1:0] REG_GAIN_FEEDBACK = 2'd2;
  localparam logic [CfgIndexBits-1:0] REG_COMB_MODE     = 2'd3;

  // Sign pairs (direct, feedback) applied to the stored value.
  localparam logic [ModeBits-1:0] MODE_NEG_B_POS_A = 2'd0;
  localparam logic [ModeBits-1:0] MODE_POS_B_NEG_A = 2'd1;
  localparam logic [ModeBits-1:0] MODE_POS_B_POS_A = 2'd2;
  localparam logic [ModeBits-1:0] MODE_NEG_B_NEG_A = 2'd3;

  // Reset value of the delay length register.
  localparam logic [DelayLenBits-1:0] DELAY_LENGTH_RESET = 8'd1;

endpackage

`default_nettype wire

// ----- hdl/signed_comb_filter_core.sv -----
// Top level of the signed comb filter core: delay memory, datapath and control.
//
// Feedback comb filter on signed Q1.15 samples with Q2.14 gains. Each transfer
// on the input channel yields exactly one output sample, y = b*x + d, where d is
// the sample stored delay_length entries earlier; the value written back into
// the delay line is +-b*x +-a*y, picked by comb_mode, saturated to the sample
// range. An accepted sample passes through the output stage registers into the
// output register, and no new sample is accepted while the previous one is still
// in the output stage: the delay memory is read in the accept cycle, the output
// is formed in the next one, and the feedback product is written back while the
// following sample is read, with a bypass when both touch the same entry. A full
// output register that the receiving side stalls holds the block. After reset
// the block zeroes its delay memory, one entry per cycle, before it accepts the
// first sample; configuration writes are taken at any time.
`default_nettype none

module signed_comb_filter_core
  import scf_pkg::*;
#(
  parameter int DELAY_DEPTH = DefaultDelayDepth,
  parameter int SAMPLE_BITS = DefaultSampleBits
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write port.
  input  wire logic                          cfg_en,
  input  wire logic [CfgIndexBits-1:0]       cfg_index,
  input  wire logic [CfgDataBits-1:0]        cfg_data,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  // Output channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_sample
);

  localparam int AddrBits  = $clog2(DELAY_DEPTH);
  localparam int ProdBits  = SAMPLE_BITS + GainBits;
  localparam int TermBits  = ProdBits - GainFrac;
  localparam int SumBits   = SAMPLE_BITS + 4;
  localparam int RecipFrac = 16;
  localparam int RecipBits = RecipFrac + 1;
  localparam logic [RecipBits-1:0] Recip =
      RecipBits'((2 ** RecipFrac + DELAY_DEPTH - 1) / DELAY_DEPTH);
  localparam logic [AddrBits-1:0] LastAddr = AddrBits'(DELAY_DEPTH - 1);
  localparam logic [AddrBits:0]   DepthExt = (AddrBits + 1)'(DELAY_DEPTH);
  localparam logic signed [SumBits-1:0] SatHi = {5'b00000, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SumBits-1:0] SatLo = {5'b11111, {(SAMPLE_BITS - 1){1'b0}}};

  // Configuration registers.
  logic [DelayLenBits-1:0]      delay_length;
  logic signed [GainBits-1:0]   gain_direct;
  logic signed [GainBits-1:0]   gain_feedback;
  logic [ModeBits-1:0]          comb_mode;

  // Delay memory and its ports.
  logic [SAMPLE_BITS-1:0]       delay_mem [DELAY_DEPTH];
  logic [SAMPLE_BITS-1:0]       rd_data;
  logic                         wr_en;
  logic [AddrBits-1:0]          wr_addr;
  logic [SAMPLE_BITS-1:0]       wr_data;

  // Clearing pass and write pointer.
  logic                         clearing;
  logic [AddrBits-1:0]          clr_addr;
  logic [AddrBits-1:0]          write_pointer;
  logic [AddrBits-1:0]          write_pointer_next;

  // Read address arithmetic.
  logic [DelayLenBits+RecipBits-1:0] dl_prod;
  logic [DelayLenBits-1:0]      dl_quot;
  logic [DelayLenBits-1:0]      dl_rem;
  logic [AddrBits:0]            dl_mod;
  logic [AddrBits:0]            wp_ext;
  logic [AddrBits:0]            rp_ext;
  logic [AddrBits-1:0]          rd_addr;

  // Direct path product.
  logic signed [ProdBits-1:0]   bx_prod;
  logic signed [TermBits-1:0]   bx_term;
  logic                         accept;

  // Output stage.
  logic                         s2_valid;
  logic signed [TermBits-1:0]   s2_bx;
  logic [AddrBits-1:0]          s2_addr;
  logic                         s2_fwd;
  logic [SAMPLE_BITS-1:0]       s2_fwd_data;
  logic signed [SAMPLE_BITS-1:0] s2_delayed;
  logic signed [SumBits-1:0]    y_sum;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                         s2_done;

  // Feedback stage.
  logic                         s3_valid;
  logic signed [TermBits-1:0]   s3_bx;
  logic signed [SAMPLE_BITS-1:0] s3_y;
  logic [AddrBits-1:0]          s3_addr;
  logic signed [ProdBits-1:0]   ay_prod;
  logic signed [TermBits-1:0]   ay_term;
  logic                         neg_b;
  logic                         neg_a;
  logic signed [SumBits-1:0]    term_b;
  logic signed [SumBits-1:0]    term_a;
  logic signed [SumBits-1:0]    s_sum;
  logic [SAMPLE_BITS-1:0]       s_sat;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length  <= DELAY_LENGTH_RESET;
      gain_direct   <= '0;
      gain_feedback <= '0;
      comb_mode     <= '0;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_DELAY_LENGTH:  delay_length  <= cfg_data[DelayLenBits-1:0];
        REG_GAIN_DIRECT:   gain_direct   <= $signed(cfg_data[GainBits-1:0]);
        REG_GAIN_FEEDBACK: gain_feedback <= $signed(cfg_data[GainBits-1:0]);
        REG_COMB_MODE:     comb_mode     <= cfg_data[ModeBits-1:0];
        default: ;
      endcase
    end
  end

  // Delay length modulo the depth, by a reciprocal multiply; exact for 8-bit values.
  always_comb begin
    dl_prod = (DelayLenBits + RecipBits)'(delay_length * Recip);
    dl_quot = dl_prod[RecipFrac +: DelayLenBits];
    dl_rem  = delay_length - DelayLenBits'(dl_quot * DELAY_DEPTH);
    dl_mod  = (AddrBits + 1)'(dl_rem);
  end

  // Read pointer sits the delay length behind the write pointer, wrapping.
  always_comb begin
    wp_ext = {1'b0, write_pointer};
    if (wp_ext >= dl_mod) begin
      rp_ext = wp_ext - dl_mod;
    end else begin
      rp_ext = wp_ext + DepthExt - dl_mod;
    end
    rd_addr = rp_ext[AddrBits-1:0];
    write_pointer_next = (write_pointer == LastAddr) ? '0 : write_pointer + 1'b1;
  end

  // Input handshake and direct path product.
  assign in_stall = clearing | s2_valid;
  assign accept   = in_valid & ~in_stall;
  assign bx_prod  = ProdBits'(gain_direct) * ProdBits'(in_sample);
  assign bx_term  = $signed(bx_prod[ProdBits-1:GainFrac]);

  // The output stage finishes when the output register is free or being drained.
  assign s2_done = s2_valid & (~out_valid | ~out_stall);

  // Delayed sample, bypassing the memory when it was written in the read cycle.
  always_comb begin
    s2_delayed = s2_fwd ? $signed(s2_fwd_data) : $signed(rd_data);
    y_sum = SumBits'(s2_bx) + SumBits'(s2_delayed);
    if (y_sum > SatHi) begin
      y_sat = SatHi[SAMPLE_BITS-1:0];
    end else if (y_sum < SatLo) begin
      y_sat = SatLo[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_sum[SAMPLE_BITS-1:0];
    end
  end

  // Feedback term and the saturated value written back.
  always_comb begin
    ay_prod = ProdBits'(gain_feedback) * ProdBits'(s3_y);
    ay_term = $signed(ay_prod[ProdBits-1:GainFrac]);
    neg_b   = (comb_mode == MODE_NEG_B_POS_A) || (comb_mode == MODE_NEG_B_NEG_A);
    neg_a   = (comb_mode == MODE_POS_B_NEG_A) || (comb_mode == MODE_NEG_B_NEG_A);
    term_b  = neg_b ? -SumBits'(s3_bx) : SumBits'(s3_bx);
    term_a  = neg_a ? -SumBits'(ay_term) : SumBits'(ay_term);
    s_sum   = term_b + term_a;
    if (s_sum > SatHi) begin
      s_sat = SatHi[SAMPLE_BITS-1:0];
    end else if (s_sum < SatLo) begin
      s_sat = SatLo[SAMPLE_BITS-1:0];
    end else begin
      s_sat = s_sum[SAMPLE_BITS-1:0];
    end
  end

  // Memory write source: zeros during the clearing pass, else the feedback stage.
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = s3_valid;
      wr_addr = s3_addr;
      wr_data = s_sat;
    end
  end

  // Delay memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      delay_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data <= delay_mem[rd_addr];
    end
  end

  // Clearing pass and write pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_addr      <= '0;
      write_pointer <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= (clr_addr == LastAddr) ? '0 : clr_addr + 1'b1;
        if (clr_addr == LastAddr) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        write_pointer <= write_pointer_next;
      end
    end
  end

  // Output stage registers, loaded on an input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (accept) begin
      s2_valid <= 1'b1;
    end else if (s2_done) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_bx       <= bx_term;
      s2_addr     <= write_pointer;
      s2_fwd      <= s3_valid & (s3_addr == rd_addr);
      s2_fwd_data <= s_sat;
    end
  end

  // Output register; it holds while the receiving side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_done) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      out_sample <= y_sat;
    end
  end

  // Feedback stage registers; this stage never stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_done;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done) begin
      s3_bx   <= s2_bx;
      s3_y    <= y_sat;
      s3_addr <= s2_addr;
    end
  end

endmodule

`default_nettype wire
